[src/bsa_pkg.sv]
// Shared types and codes for the banker's-algorithm admission block.
// No dependencies; imported by the top level of the block.
package bsa_pkg;

    // Stream and configuration field widths
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 32;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;
    localparam int FIELD_W     = 8;
    localparam int FUNC_W      = 2;
    localparam int PROC_W      = 3;
    localparam int STATUS_W    = 3;
    localparam int NUM_FIELDS  = 3;

    // Request function codes
    typedef enum logic [FUNC_W-1:0] {
        FUNC_START   = 2'd0,
        FUNC_LOAD    = 2'd1,
        FUNC_REQUEST = 2'd2,
        FUNC_BAD     = 2'd3
    } func_t;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_GRANTED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_COMPLETE = 3'd1;
    localparam logic [STATUS_W-1:0] ST_UNSAFE   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_SHORT    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_INVALID  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_SETUP    = 3'd5;

endpackage

[src/bsa_ram.sv]
// Simple dual-port RAM with registered read, one row per process.
// Depends on nothing; used by the top level for holdings and maximum rows.
module bsa_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 5,
    parameter int ADDR_BITS = 3
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [ADDR_BITS-1:0] waddr,
    input  logic [WIDTH-1:0]     wdata,
    input  logic [ADDR_BITS-1:0] raddr,
    output logic [WIDTH-1:0]     rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end
endmodule

[src/bankers_safety_allocator_top.sv]
// Banker's-algorithm admission block: start, load maximum row, request with safety walk.
// Start, load, bad-func and bad-process items go straight to the response state; requests
// rejected at the check respond from S_CHECK; an admitted request runs the safety walk,
// reading a row (S_WALK_RD) and testing it (S_WALK_CHK), restarting at row 0 whenever a
// row finishes. One request in flight: the next is accepted only back in S_IDLE.
// Reset (rst_n, async low) clears available, holdings valid flags, finished flags and totals.
module bankers_safety_allocator_top #(
    parameter int PROCS = 5,
    parameter int TYPES = 3,
    parameter int AMOUNT_BITS = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // func[1:0], process[4:2], amount_0[12:5], amount_1[20:13], amount_2[28:21]
    input  logic [bsa_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // status[2:0], avail_0[10:3], avail_1[18:11], avail_2[26:19], all_finished[27]
    output logic [bsa_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [bsa_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [bsa_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import bsa_pkg::*;

    localparam int AW = AMOUNT_BITS;
    localparam int WW = AMOUNT_BITS + 5;
    localparam int PW = (PROCS > 1) ? $clog2(PROCS) : 1;
    localparam int RW = TYPES * AMOUNT_BITS;
    localparam logic [PW-1:0] LAST_P = PW'(PROCS - 1);

    typedef logic [TYPES-1:0][AW-1:0] row_t;
    typedef logic [TYPES-1:0][WW-1:0] wrow_t;
    typedef enum logic [2:0] {
        S_IDLE, S_CHECK, S_WALK_RD, S_WALK_CHK, S_FINISH, S_RESP
    } state_t;

    state_t state_reg;
    logic [CFG_DATA_W-1:0] total_reg [NUM_FIELDS];
    row_t avail_reg, req_reg, held_old_reg, held_new_reg, max_row_reg;
    wrow_t work_reg;
    logic [PROCS-1:0] done_reg, held_vld_reg, fin_reg;
    logic rd_vld_reg;
    logic [PW-1:0] proc_reg, walk_p_reg;
    logic [STATUS_W-1:0] status_reg, out_status_reg;
    logic out_valid_reg, out_all_reg;
    logic [FIELD_W-1:0] out_avail_reg [NUM_FIELDS];

    // input decode
    logic accept;
    func_t in_func;
    logic [4:0] in_proc_ext;
    logic in_proc_ok;
    logic [PW-1:0] in_proc_idx;
    row_t in_req;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign in_func       = func_t'(s_axis_tdata[1:0]);
    assign in_proc_ext   = {2'b00, s_axis_tdata[4:2]};
    assign in_proc_ok    = in_proc_ext < 5'(PROCS);
    assign in_proc_idx   = in_proc_ext[PW-1:0];

    always_comb
    begin
        logic [15:0] ext;
        for (int t = 0; t < TYPES; t++)
        begin
            ext = {8'b0, s_axis_tdata[5 + 8*t +: 8]};
            in_req[t] = ext[AW-1:0];
        end
    end

    // row RAMs
    logic held_we, max_we;
    logic [PW-1:0] rd_addr, max_waddr;
    row_t held_q, max_q, held_row, held_wdata;
    logic [RW-1:0] held_rdata, max_rdata;

    assign rd_addr = (state_reg == S_IDLE) ? in_proc_idx : walk_p_reg;

    bsa_ram #(.WIDTH(RW), .DEPTH(PROCS), .ADDR_BITS(PW)) u_held_ram (
        .clk   (clk),
        .we    (held_we),
        .waddr (proc_reg),
        .wdata (held_wdata),
        .raddr (rd_addr),
        .rdata (held_rdata)
    );

    assign max_we    = accept && (in_func == FUNC_LOAD) && in_proc_ok;
    assign max_waddr = in_proc_idx;

    bsa_ram #(.WIDTH(RW), .DEPTH(PROCS), .ADDR_BITS(PW)) u_max_ram (
        .clk   (clk),
        .we    (max_we),
        .waddr (max_waddr),
        .wdata (in_req),
        .raddr (rd_addr),
        .rdata (max_rdata)
    );

    assign held_q   = held_rdata;
    assign max_q    = max_rdata;
    assign held_row = rd_vld_reg ? held_q : '0;

    // request checks, tentative allocation, walk test
    logic over_need, over_avail, can_fin, safe, complete;
    row_t held_plus, avail_sub, avail_sat;
    always_comb
    begin
        logic [AW:0] s;
        over_need  = 1'b0;
        over_avail = 1'b0;
        can_fin    = 1'b1;
        complete   = 1'b1;
        for (int t = 0; t < TYPES; t++)
        begin
            if ((AW+1)'(req_reg[t]) + (AW+1)'(held_row[t]) > (AW+1)'(max_q[t]))
                over_need = 1'b1;
            if (req_reg[t] > avail_reg[t])
                over_avail = 1'b1;
            if ((WW+1)'(work_reg[t]) + (WW+1)'(held_row[t]) < (WW+1)'(max_q[t]))
                can_fin = 1'b0;
            if (held_new_reg[t] < max_row_reg[t])
                complete = 1'b0;
            held_plus[t] = held_row[t] + req_reg[t];
            avail_sub[t] = avail_reg[t] - req_reg[t];
            s = (AW+1)'(avail_reg[t]) + (AW+1)'(held_new_reg[t]);
            avail_sat[t] = s[AW] ? {AW{1'b1}} : s[AW-1:0];
        end
        safe = &fin_reg;
    end

    assign held_we = (state_reg == S_CHECK && !done_reg[proc_reg] && !over_need
                      && !over_avail)
                     || (state_reg == S_FINISH && !safe);
    assign held_wdata = (state_reg == S_CHECK) ? held_plus : held_old_reg;

    // configuration writes
    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_FIELDS; k++)
                total_reg[k] <= '0;
        end
        else if (cfg_valid && cfg_ready && cfg_index < CFG_INDEX_W'(NUM_FIELDS))
        begin
            total_reg[cfg_index] <= cfg_data;
        end
    end

    // sequencer, state and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        logic [15:0] text;
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            avail_reg     <= '0;
            done_reg      <= '0;
            held_vld_reg  <= '0;
            rd_vld_reg    <= 1'b0;
            fin_reg       <= '0;
            walk_p_reg    <= '0;
            proc_reg      <= '0;
            status_reg    <= ST_SETUP;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= held_vld_reg[rd_addr];
            if (held_we)
                held_vld_reg[proc_reg] <= 1'b1;

            // result valid: set when a result lands, cleared when taken
            if (state_reg == S_RESP && (!out_valid_reg || m_axis_tready))
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        req_reg  <= in_req;
                        proc_reg <= in_proc_idx;
                        state_reg <= S_RESP;
                        unique case (in_func)
                            FUNC_START:
                            begin
                                for (int t = 0; t < TYPES; t++)
                                begin
                                    text = {8'b0, total_reg[t]};
                                    avail_reg[t] <= text[AW-1:0];
                                end
                                done_reg     <= '0;
                                held_vld_reg <= '0;
                                status_reg   <= ST_SETUP;
                            end
                            FUNC_LOAD:
                                status_reg <= in_proc_ok ? ST_SETUP : ST_INVALID;
                            FUNC_REQUEST:
                            begin
                                status_reg <= ST_INVALID;
                                if (in_proc_ok)
                                    state_reg <= S_CHECK;
                            end
                            FUNC_BAD:
                                status_reg <= ST_INVALID;
                            default:
                                status_reg <= ST_INVALID;
                        endcase
                    end
                end
                S_CHECK:
                begin
                    held_old_reg <= held_row;
                    held_new_reg <= held_plus;
                    max_row_reg  <= max_q;
                    priority if (done_reg[proc_reg] || over_need)
                    begin
                        status_reg <= ST_INVALID;
                        state_reg  <= S_RESP;
                    end
                    else if (over_avail)
                    begin
                        status_reg <= ST_SHORT;
                        state_reg  <= S_RESP;
                    end
                    else
                    begin
                        avail_reg  <= avail_sub;
                        for (int t = 0; t < TYPES; t++)
                            work_reg[t] <= WW'(avail_sub[t]);
                        fin_reg    <= done_reg;
                        walk_p_reg <= '0;
                        state_reg  <= S_WALK_RD;
                    end
                end
                S_WALK_RD:
                    state_reg <= S_WALK_CHK;
                S_WALK_CHK:
                begin
                    priority if (!fin_reg[walk_p_reg] && can_fin)
                    begin
                        fin_reg[walk_p_reg] <= 1'b1;
                        for (int t = 0; t < TYPES; t++)
                            work_reg[t] <= work_reg[t] + WW'(held_row[t]);
                        walk_p_reg <= '0;
                        state_reg  <= S_WALK_RD;
                    end
                    else if (walk_p_reg == LAST_P)
                        state_reg <= S_FINISH;
                    else
                    begin
                        walk_p_reg <= walk_p_reg + 1'b1;
                        state_reg  <= S_WALK_RD;
                    end
                end
                S_FINISH:
                begin
                    state_reg <= S_RESP;
                    priority if (!safe)
                    begin
                        for (int t = 0; t < TYPES; t++)
                            avail_reg[t] <= avail_reg[t] + req_reg[t];
                        status_reg <= ST_UNSAFE;
                    end
                    else if (complete)
                    begin
                        avail_reg <= avail_sat;
                        held_vld_reg[proc_reg] <= 1'b0;
                        done_reg[proc_reg] <= 1'b1;
                        status_reg <= ST_COMPLETE;
                    end
                    else
                        status_reg <= ST_GRANTED;
                end
                S_RESP:
                begin
                    if (!out_valid_reg || m_axis_tready)
                        state_reg <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    // result payload capture
    always_ff @(posedge clk)
    begin
        logic [15:0] aext;
        if (state_reg == S_RESP && (!out_valid_reg || m_axis_tready))
        begin
            out_status_reg <= status_reg;
            out_all_reg    <= &done_reg;
            for (int k = 0; k < NUM_FIELDS; k++)
            begin
                aext = '0;
                if (k < TYPES)
                    aext = 16'(avail_reg[k % TYPES]);
                out_avail_reg[k] <= aext[7:0];
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0, out_all_reg, out_avail_reg[2], out_avail_reg[1],
                            out_avail_reg[0], out_status_reg};

    // checks
    a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_func == FUNC_START) |=> (done_reg == '0 && held_vld_reg == '0))
        else $error("start request did not clear flags");
    a_walk_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK_CHK) |-> (walk_p_reg <= LAST_P))
        else $error("walk pointer out of range");
    a_ram_write_state: assert property (@(posedge clk) disable iff (!rst_n)
        held_we |-> (state_reg == S_CHECK || state_reg == S_FINISH))
        else $error("holdings written outside check or finish");
    a_resp_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RESP && (!out_valid_reg || m_axis_tready)) |=> out_valid_reg)
        else $error("result not presented");
endmodule
